### hdl/dvs_pkg.sv
// Shared types, codes and constants of the distance volume spatializer.
package dvs_pkg;

    // Field widths of the stream items
    localparam int COORD_W   = 16;
    localparam int CHAN_W    = 4;
    localparam int VOL_W     = 16;
    localparam int OPCODE_W  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int RADIUS_W  = 15;
    localparam int WRAP_W    = 15;

    // Default table depth
    localparam int DEFAULT_CHANNELS = 16;

    // Divider: quotient bits and divisor bits
    localparam int DIV_Q_W = 18;
    localparam int DIV_D_W = 16;

    // Square root unit: radicand bits (even) and root bits
    localparam int ROOT_IN_W  = 34;
    localparam int ROOT_OUT_W = ROOT_IN_W / 2;

    // Fixed-point constants
    localparam logic [14:0] Q14_ONE = 15'd16384;
    localparam logic [15:0] VOL_MAX = 16'hFFFF;

    // Register reset values
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd1024;
    localparam logic [VOL_W-1:0]    MASTER_RESET = 16'd16384;
    localparam logic [COORD_W-1:0]  TARGET_RESET = 16'd2048;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET_POS = 3'd0,
        OP_REMOVE  = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_TARGET  = 3'd3,
        OP_UPDATE  = 3'd4
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS = 3'd0,
        REG_MASTER = 3'd1,
        REG_WRAP_X = 3'd2,
        REG_WRAP_Y = 3'd3,
        REG_AUTO   = 3'd4
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_WRAP,
        S_WDIV,
        S_WMUL,
        S_WSUB,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_GAIN,
        S_GDIV,
        S_VOL,
        S_EMIT
    } t_state;

endpackage

### hdl/distance_volume_spatializer_core.sv
// Top level: position memory, update sequencer and volume datapath.
//
//  Channel  | Direction | Contents
//  ---------+-----------+-------------------------------------------------
//  s stream | in        | tuser: opcode; tdata: channel, x_coord, y_coord
//  m stream | out       | tdata: out_channel, volume; tlast: last
//  cfg      | in        | write enable, register index, write data
//
// One item is taken at a time. Set, remove and target items start an update
// walk while auto update is on; an update visits each channel and, for a valid
// one, runs the wrap divisions, the root and, within radius, the gain division.
// Reset is synchronous and clears the valid bits; no clearing pass is run.
// A stalled output holds the sequencer in its emit step; input is taken
// again once the run has placed its final result in the output register.
module distance_volume_spatializer_core
    import dvs_pkg::*;
#(
    parameter int CHANNELS = DEFAULT_CHANNELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [3:0] channel, [19:4] x_coord, [35:20] y_coord, [39:36] zero
    input  logic [39:0]          i_s_tdata,
    // [2:0] opcode
    input  logic [OPCODE_W-1:0]  i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [3:0] out_channel, [19:4] volume, [23:20] zero
    output logic [23:0]          o_m_tdata,
    output logic                 o_m_tlast,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [CFG_DAT_W-1:0] i_cfg_wdata
);

    localparam int NCH = (CHANNELS > 16) ? 16 : CHANNELS;
    localparam int AW  = (NCH > 1) ? $clog2(NCH) : 1;

    // Configuration registers
    logic [RADIUS_W-1:0] r_radius;
    logic [VOL_W-1:0]    r_master;
    logic [WRAP_W-1:0]   r_wrap_x;
    logic [WRAP_W-1:0]   r_wrap_y;
    logic                r_auto;

    // State outside the memory
    logic [NCH-1:0]            r_valid;
    logic signed [COORD_W-1:0] r_tgt_x;
    logic signed [COORD_W-1:0] r_tgt_y;

    // Position memory, x in the low half
    logic [2*COORD_W-1:0] r_mem [NCH];
    logic [2*COORD_W-1:0] r_rd_data;

    t_state r_state, n_state;
    logic [AW-1:0] r_idx;

    // Input item fields
    t_opcode                   in_op;
    logic [CHAN_W-1:0]         in_ch;
    logic [COORD_W-1:0]        in_x;
    logic [COORD_W-1:0]        in_y;
    logic                      accept;
    logic                      ch_ok;

    assign in_op  = t_opcode'(i_s_tuser);
    assign in_ch  = i_s_tdata[3:0];
    assign in_x   = i_s_tdata[19:4];
    assign in_y   = i_s_tdata[35:20];
    assign ch_ok  = (32'(in_ch) < CHANNELS);
    assign accept = i_s_tvalid && o_s_tready;

    // Datapath registers
    logic signed [16:0] r_dx, r_dy;
    logic               r_neg_x, r_neg_y;
    logic signed [34:0] r_pw_x, r_pw_y;
    logic [15:0]        r_ax, r_ay;
    logic [31:0]        r_sq_x, r_sq_y;
    logic [14:0]        r_gain;
    logic [30:0]        r_prod;
    logic               r_m_valid;
    logic [CHAN_W-1:0]  r_m_ch;
    logic [VOL_W-1:0]   r_m_vol;
    logic               r_m_last;

    // Sequencer strobes
    logic rd_en, wdiv_start, root_start, gdiv_start, emit, slot_free;

    // Shared units
    logic [DIV_D_W-1:0] divx_rem0, divx_den, divx_rem, divy_rem;
    logic [DIV_Q_W-1:0] divx_num, divx_quot, divy_num, divy_quot;
    logic               divx_start, divx_done, divy_done;
    logic [ROOT_OUT_W-1:0] root;
    logic               root_done;

    logic [RADIUS_W-1:0] r_eff;
    logic                more_valid;
    logic signed [18:0]  num_x, num_y;

    assign r_eff     = (r_radius == '0) ? RADIUS_W'(1) : r_radius;
    assign slot_free = !r_m_valid || i_m_tready;

    // Any valid channel above the current index keeps the run going; none closes it
    always_comb begin
        more_valid = 1'b0;
        for (int i = 0; i < NCH; i++) begin
            if (r_valid[i] && (AW'(i) > r_idx)) more_valid = 1'b1;
        end
    end

    // Wrap numerators 2*d + w
    assign num_x = {r_dx[16], r_dx, 1'b0} + {4'b0, r_wrap_x};
    assign num_y = {r_dy[16], r_dy, 1'b0} + {4'b0, r_wrap_y};

    // The x divider also serves the gain division
    always_comb begin
        if (r_state == S_GAIN) begin
            divx_rem0 = DIV_D_W'(root >> 4);
            divx_num  = {root[3:0], 14'b0};
            divx_den  = {1'b0, r_eff};
        end else begin
            divx_rem0 = '0;
            divx_num  = num_x[18] ? DIV_Q_W'(-num_x) : num_x[17:0];
            divx_den  = {r_wrap_x, 1'b0};
        end
        divy_num   = num_y[18] ? DIV_Q_W'(-num_y) : num_y[17:0];
        divx_start = wdiv_start || gdiv_start;
    end

    dvs_divider u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (divx_start),
        .i_rem0  (divx_rem0),
        .i_num   (divx_num),
        .i_den   (divx_den),
        .o_quot  (divx_quot),
        .o_rem   (divx_rem),
        .o_done  (divx_done)
    );

    dvs_divider u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (wdiv_start),
        .i_rem0  ({DIV_D_W{1'b0}}),
        .i_num   (divy_num),
        .i_den   ({r_wrap_y, 1'b0}),
        .o_quot  (divy_quot),
        .o_rem   (divy_rem),
        .o_done  (divy_done)
    );

    dvs_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand (ROOT_IN_W'({1'b0, r_sq_x} + {1'b0, r_sq_y})),
        .o_root     (root),
        .o_done     (root_done)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (in_op) inside
                        OP_SET_POS, OP_REMOVE: if (ch_ok && r_auto) n_state = S_SCAN;
                        OP_TARGET: if (r_auto) n_state = S_SCAN;
                        OP_UPDATE: n_state = S_SCAN;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_valid[r_idx])                 n_state = S_READ;
                else if (r_idx == AW'(NCH - 1))     n_state = S_IDLE;
            end
            S_READ:   n_state = S_WRAP;
            S_WRAP:   n_state = S_WDIV;
            S_WDIV:   if (divx_done && divy_done) n_state = S_WMUL;
            S_WMUL:   n_state = S_WSUB;
            S_WSUB:   n_state = S_SQUARE;
            S_SQUARE: n_state = S_SUM;
            S_SUM:    n_state = S_ROOT;
            S_ROOT:   if (root_done) n_state = S_GAIN;
            S_GAIN:   n_state = (32'(root) >= 32'(r_eff)) ? S_VOL : S_GDIV;
            S_GDIV:   if (divx_done) n_state = S_VOL;
            S_VOL:    n_state = S_EMIT;
            S_EMIT: begin
                if (slot_free) n_state = more_valid ? S_SCAN : S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_s_tready = (r_state == S_IDLE);
        rd_en      = (r_state == S_SCAN) && r_valid[r_idx];
        wdiv_start = (r_state == S_WRAP);
        root_start = (r_state == S_SUM);
        gdiv_start = (r_state == S_GAIN) && (32'(root) < 32'(r_eff));
        emit       = (r_state == S_EMIT) && slot_free;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_valid   <= '0;
            r_tgt_x   <= TARGET_RESET;
            r_tgt_y   <= TARGET_RESET;
            r_radius  <= RADIUS_RESET;
            r_master  <= MASTER_RESET;
            r_wrap_x  <= '0;
            r_wrap_y  <= '0;
            r_auto    <= 1'b1;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // Configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_RADIUS: r_radius <= i_cfg_wdata[RADIUS_W-1:0];
                    REG_MASTER: r_master <= i_cfg_wdata;
                    REG_WRAP_X: r_wrap_x <= i_cfg_wdata[WRAP_W-1:0];
                    REG_WRAP_Y: r_wrap_y <= i_cfg_wdata[WRAP_W-1:0];
                    REG_AUTO:   r_auto   <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            // Item decode
            if (accept) begin
                case (in_op)
                    OP_SET_POS: if (ch_ok) r_valid[in_ch[AW-1:0]] <= 1'b1;
                    OP_REMOVE:  if (ch_ok) r_valid[in_ch[AW-1:0]] <= 1'b0;
                    OP_CLEAR:   r_valid <= '0;
                    OP_TARGET: begin
                        r_tgt_x <= in_x;
                        r_tgt_y <= in_y;
                    end
                    default: ;
                endcase
            end

            // Channel walk
            if (r_state == S_IDLE) begin
                r_idx <= '0;
            end else if ((r_state == S_SCAN) && !r_valid[r_idx] &&
                         (r_idx != AW'(NCH - 1))) begin
                r_idx <= r_idx + 1'b1;
            end else if (emit && more_valid) begin
                r_idx <= r_idx + 1'b1;
            end

            // Output register
            if (emit)            r_m_valid <= 1'b1;
            else if (i_m_tready) r_m_valid <= 1'b0;
        end
    end

    // Position memory: written by set position, read by the walk
    always_ff @(posedge i_clk) begin
        if (accept && (in_op == OP_SET_POS) && ch_ok) begin
            r_mem[in_ch[AW-1:0]] <= {in_y, in_x};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // Volume datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_READ: begin
                r_dx <= 17'($signed(r_rd_data[15:0])) - 17'(r_tgt_x);
                r_dy <= 17'($signed(r_rd_data[31:16])) - 17'(r_tgt_y);
            end
            S_WRAP: begin
                r_neg_x <= num_x[18];
                r_neg_y <= num_y[18];
            end
            S_WMUL: begin
                // Floor quotient times the interval
                r_pw_x <= (r_neg_x ?
                           -$signed({1'b0, divx_quot + 18'(divx_rem != '0)}) :
                           $signed({1'b0, divx_quot})) * $signed({1'b0, r_wrap_x});
                r_pw_y <= (r_neg_y ?
                           -$signed({1'b0, divy_quot + 18'(divy_rem != '0)}) :
                           $signed({1'b0, divy_quot})) * $signed({1'b0, r_wrap_y});
            end
            S_WSUB: begin
                logic signed [16:0] wx, wy;
                wx = (r_wrap_x != '0) ? 17'(35'(r_dx) - r_pw_x) : r_dx;
                wy = (r_wrap_y != '0) ? 17'(35'(r_dy) - r_pw_y) : r_dy;
                r_ax <= wx[16] ? 16'(-wx) : wx[15:0];
                r_ay <= wy[16] ? 16'(-wy) : wy[15:0];
            end
            S_SQUARE: begin
                r_sq_x <= r_ax * r_ax;
                r_sq_y <= r_ay * r_ay;
            end
            S_GAIN:   r_gain <= '0;
            S_GDIV:   if (divx_done) r_gain <= Q14_ONE - 15'(divx_quot);
            S_VOL:    r_prod <= r_gain * r_master;
            S_EMIT: begin
                if (slot_free) begin
                    r_m_ch   <= CHAN_W'(r_idx);
                    r_m_vol  <= (r_prod[30:30] != '0) ? VOL_MAX : r_prod[29:14];
                    r_m_last <= !more_valid;
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'b0, r_m_vol, r_m_ch};
    assign o_m_tlast  = r_m_last;

endmodule

### hdl/dvs_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
module dvs_divider
    import dvs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIV_D_W-1:0] i_rem0,
    input  logic [DIV_Q_W-1:0] i_num,
    input  logic [DIV_D_W-1:0] i_den,
    output logic [DIV_Q_W-1:0] o_quot,
    output logic [DIV_D_W-1:0] o_rem,
    output logic               o_done
);

    localparam int CNT_W = $clog2(DIV_Q_W);

    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_Q_W-1:0] r_sh;
    logic [DIV_D_W-1:0] r_den;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    logic [DIV_D_W:0]   trial;
    logic               ge;
    logic [DIV_D_W-1:0] n_rem;

    // One trial subtraction of the partial remainder
    always_comb begin
        trial = {r_rem, r_sh[DIV_Q_W-1]};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? DIV_D_W'(trial - {1'b0, r_den}) : DIV_D_W'(trial);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem0;
            r_sh  <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh  <= {r_sh[DIV_Q_W-2:0], ge};
        end
    end

    assign o_quot = r_sh;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

### hdl/dvs_sqrt.sv
// Iterative integer square root, one root bit per cycle.
module dvs_sqrt
    import dvs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [ROOT_IN_W-1:0]  i_radicand,
    output logic [ROOT_OUT_W-1:0] o_root,
    output logic                  o_done
);

    localparam int CNT_W = $clog2(ROOT_OUT_W);

    logic [ROOT_IN_W-1:0] r_n;
    logic [ROOT_IN_W-1:0] r_res;
    logic [ROOT_IN_W-1:0] r_bit;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [ROOT_IN_W-1:0] trial;
    logic                 ge;

    always_comb begin
        trial = r_res + r_bit;
        ge    = (r_n >= trial);
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_OUT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Digit recurrence
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_radicand;
            r_res <= '0;
            r_bit <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
        end else if (r_busy) begin
            if (ge) begin
                r_n   <= r_n - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_res[ROOT_OUT_W-1:0];
    assign o_done = r_done;

endmodule
